### rtl/radial_vignette_pixel_top_macros.svh
// Assertion macros shared by the checker of radial_vignette_pixel_top.
// Needs signals clk and arst_n in the scope of use.
`ifndef RADIAL_VIGNETTE_PIXEL_TOP_MACROS_SVH
`define RADIAL_VIGNETTE_PIXEL_TOP_MACROS_SVH

// Property checked only outside reset
`define RVP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define RVP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rvp_pkg.sv
// Shared types and constants of the radial vignette pixel block.
// No dependencies.
`default_nettype none
package rvp_pkg;
	localparam int FRAC     = 16;
	localparam int DIM_W    = 13;
	localparam int CRD_W    = 12;
	localparam int ADX_W    = 13;
	localparam int SQ_W     = 26;
	localparam int NUM_W    = 27;
	localparam int DEN_W    = 26;
	localparam int RATIO_W  = 18;
	localparam int D_W      = 17;
	localparam int FX_W     = 17;
	localparam int CFG_W    = 17;

	localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
	localparam logic [FX_W-1:0]  ONE_FX  = 17'h10000;

	typedef enum logic [1:0] {
		CFG_WIDTH    = 2'd0,
		CFG_HEIGHT   = 2'd1,
		CFG_RADIUS   = 2'd2,
		CFG_STRENGTH = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;
endpackage
`default_nettype wire

### rtl/rvp_div_pipe.sv
// Pipelined restoring divider, two quotient bits per stage, with sideband.
// Standalone; remainder input must be below the divisor.
`default_nettype none
module rvp_div_pipe #(
	parameter int RW = 26,
	parameter int QW = 18,
	parameter int SW = 26
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [RW-1:0] rem0,
	input  wire logic [RW-1:0] dvs,
	input  wire logic [QW-1:0] feed,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [QW-1:0]      quot,
	output logic [SW-1:0]      side_out
);
	localparam int NS = QW / 2;

	logic          vld_s  [NS];
	logic [RW-1:0] rem_s  [NS];
	logic [RW-1:0] dvs_s  [NS];
	logic [QW-1:0] feed_s [NS];
	logic [QW-1:0] quo_s  [NS];
	logic [SW-1:0] side_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic          v_in;
		logic [RW-1:0] r_in, d_in, r_nx;
		logic [QW-1:0] f_in, q_in, f_nx, q_nx;
		logic [SW-1:0] sd_in;
		logic [RW:0]   r_w;
		logic          qb;

		if (g == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = rem0;
			assign d_in  = dvs;
			assign f_in  = feed;
			assign q_in  = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = vld_s[g-1];
			assign r_in  = rem_s[g-1];
			assign d_in  = dvs_s[g-1];
			assign f_in  = feed_s[g-1];
			assign q_in  = quo_s[g-1];
			assign sd_in = side_s[g-1];
		end

		// two shift/compare/subtract steps
		always_comb begin
			r_nx = r_in;
			f_nx = f_in;
			q_nx = q_in;
			r_w  = '0;
			qb   = 1'b0;
			for (int k = 0; k < 2; k++) begin
				r_w = {r_nx, f_nx[QW-1]};
				qb  = (r_w >= {1'b0, d_in});
				if (qb) begin
					r_w = r_w - {1'b0, d_in};
				end
				r_nx = r_w[RW-1:0];
				q_nx = {q_nx[QW-2:0], qb};
				f_nx = {f_nx[QW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= r_nx;
				dvs_s[g]  <= d_in;
				feed_s[g] <= f_nx;
				quo_s[g]  <= q_nx;
				side_s[g] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign quot      = quo_s[NS-1];
	assign side_out  = side_s[NS-1];
endmodule
`default_nettype wire

### rtl/rvp_sqrt_pipe.sv
// Pipelined digit-by-digit square root of ratio * 2^FRAC, two root bits per stage.
// Depends on rvp_pkg.
`default_nettype none
module rvp_sqrt_pipe
	import rvp_pkg::*;
#(
	parameter int SW = 25
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [RATIO_W-1:0] radicand,
	input  wire logic [SW-1:0]      side_in,
	output logic                    out_valid,
	output logic [D_W-1:0]          root,
	output logic [SW-1:0]           side_out
);
	localparam int VW = 2 * (D_W + 1);
	localparam int RT = D_W + 1;
	localparam int RW = RT + 2;
	localparam int NS = RT / 2;

	logic          vld_s  [NS];
	logic [RW-1:0] rem_s  [NS];
	logic [RT-1:0] rt_s   [NS];
	logic [VW-1:0] val_s  [NS];
	logic [SW-1:0] side_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic          v_in;
		logic [RW-1:0] r_in, r_nx;
		logic [RT-1:0] t_in, t_nx;
		logic [VW-1:0] x_in, x_nx;
		logic [SW-1:0] sd_in;
		logic [RW+1:0] rn, tr;
		logic          qb;

		if (g == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = '0;
			assign t_in  = '0;
			assign x_in  = {2'b00, radicand, {FRAC{1'b0}}};
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = vld_s[g-1];
			assign r_in  = rem_s[g-1];
			assign t_in  = rt_s[g-1];
			assign x_in  = val_s[g-1];
			assign sd_in = side_s[g-1];
		end

		// two root digits
		always_comb begin
			r_nx = r_in;
			t_nx = t_in;
			x_nx = x_in;
			rn   = '0;
			tr   = '0;
			qb   = 1'b0;
			for (int k = 0; k < 2; k++) begin
				rn = {r_nx, x_nx[VW-1:VW-2]};
				tr = {{(RW-RT){1'b0}}, t_nx, 2'b01};
				qb = (rn >= tr);
				if (qb) begin
					rn = rn - tr;
				end
				r_nx = rn[RW-1:0];
				t_nx = {t_nx[RT-2:0], qb};
				x_nx = {x_nx[VW-3:0], 2'b00};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= r_nx;
				rt_s[g]   <= t_nx;
				val_s[g]  <= x_nx;
				side_s[g] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign root      = rt_s[NS-1][D_W-1:0];
	assign side_out  = side_s[NS-1];
endmodule
`default_nettype wire

### rtl/radial_vignette_pixel_top.sv
// Radial vignette, one RGB pixel per clock, quadratic falloff beyond a radius.
// Depends on rvp_pkg, rvp_div_pipe, rvp_sqrt_pipe.
//
//  channel   direction  fields (low bit up)
//  s_axis    in         column, row, red_in, green_in, blue_in
//  m_axis    out        red_out, green_out, blue_out
//  cfg       in         image_width, image_height, inner_radius, darken_strength
//
// One pixel enters per cycle while m_axis is not stalled; the pipeline is
// three front stages, a 9-stage ratio divider, a 9-stage square root, one
// stage, an 8-stage falloff divider and three multiply stages.
// Reset clears all valid bits; config registers return to their defaults.
// A stall on m_axis freezes the whole pipeline; s_tready follows it.
`default_nettype none
module radial_vignette_pixel_top
	import rvp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [47:0]       s_tdata,   // column, row, red_in, green_in, blue_in
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [23:0]            m_tdata,   // red_out, green_out, blue_out
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);
	// config registers
	logic [DIM_W-1:0] width_q, height_q;
	logic [FX_W-1:0]  radius_q, strength_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 13'd640;
			height_q   <= 13'd480;
			radius_q   <= 17'd32768;
			strength_q <= 17'd32768;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:    width_q    <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT:   height_q   <= cfg_data[DIM_W-1:0];
				CFG_RADIUS:   radius_q   <= cfg_data;
				CFG_STRENGTH: strength_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [DIM_W-1:0] w_eff, h_eff;
	logic [FX_W-1:0]  str_eff;
	assign w_eff   = (width_q > MAX_DIM) ? MAX_DIM : width_q;
	assign h_eff   = (height_q > MAX_DIM) ? MAX_DIM : height_q;
	assign str_eff = (strength_q > ONE_FX) ? ONE_FX : strength_q;

	// global advance
	logic en;
	logic vld_s7;
	assign en       = !vld_s7 || m_tready;
	assign s_tready = en;

	rgb_t             rgb_in;
	logic [CRD_W-1:0] col_in, row_in;
	assign col_in = s_tdata[11:0];
	assign row_in = s_tdata[23:12];
	assign rgb_in = rgb_t'(s_tdata[47:24]);

	// stage 1: absolute doubled offsets
	logic [13:0]      dxr, dyr, dxn, dyn;
	logic [ADX_W-1:0] adx, ady;
	assign dxr = {1'b0, col_in, 1'b0} - {1'b0, w_eff};
	assign dyr = {1'b0, row_in, 1'b0} - {1'b0, h_eff};
	assign dxn = 14'd0 - dxr;
	assign dyn = 14'd0 - dyr;
	assign adx = dxr[13] ? dxn[ADX_W-1:0] : dxr[ADX_W-1:0];
	assign ady = dyr[13] ? dyn[ADX_W-1:0] : dyr[ADX_W-1:0];

	logic             vld_s1, vld_s2, vld_s3;
	logic [ADX_W-1:0] adx_s1, ady_s1;
	rgb_t             rgb_s1, rgb_s2, rgb_s3;
	logic [SQ_W-1:0]  adx2_s2, ady2_s2, w2_s2, h2_s2;
	logic [NUM_W-1:0] num_s3;
	logic [DEN_W-1:0] den_s3;
	logic             sat_s3, byp_s3;

	logic [NUM_W-1:0] num_c;
	logic [DEN_W-1:0] den_c;
	assign num_c = {1'b0, adx2_s2} + {1'b0, ady2_s2};
	assign den_c = w2_s2 + h2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stages 1..3: offsets, squares, sums and range flags
	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1  <= adx;
			ady_s1  <= ady;
			rgb_s1  <= rgb_in;
			adx2_s2 <= SQ_W'(adx_s1) * SQ_W'(adx_s1);
			ady2_s2 <= SQ_W'(ady_s1) * SQ_W'(ady_s1);
			w2_s2   <= SQ_W'(w_eff) * SQ_W'(w_eff);
			h2_s2   <= SQ_W'(h_eff) * SQ_W'(h_eff);
			rgb_s2  <= rgb_s1;
			num_s3  <= num_c;
			den_s3  <= den_c;
			sat_s3  <= ({1'b0, num_c} >= {den_c, 2'b00});
			byp_s3  <= (den_c == '0) || (radius_q >= ONE_FX);
			rgb_s3  <= rgb_s2;
		end
	end

	// ratio = num * 2^16 / den
	logic               vld_q1;
	logic [RATIO_W-1:0] quo1;
	logic [25:0]        side1;
	rvp_div_pipe #(.RW(DEN_W), .QW(RATIO_W), .SW(26)) u_ratio_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.rem0     ({1'b0, num_s3[NUM_W-1:2]}),
		.dvs      (den_s3),
		.feed     ({num_s3[1:0], {FRAC{1'b0}}}),
		.side_in  ({sat_s3, byp_s3, rgb_s3}),
		.out_valid(vld_q1),
		.quot     (quo1),
		.side_out (side1)
	);

	logic [RATIO_W-1:0] ratio;
	assign ratio = side1[25] ? {RATIO_W{1'b1}} : quo1;

	// normalized distance
	logic           vld_r;
	logic [D_W-1:0] dnorm;
	logic [24:0]    side2;
	rvp_sqrt_pipe #(.SW(25)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_q1),
		.radicand (ratio),
		.side_in  (side1[24:0]),
		.out_valid(vld_r),
		.root     (dnorm),
		.side_out (side2)
	);

	// stage 4: distance past radius
	logic           vld_s4, act_s4, tsat_s4;
	logic [D_W-1:0] dif_s4;
	rgb_t           rgb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dif_s4  <= dnorm - radius_q;
			act_s4  <= !side2[24] && (dnorm > radius_q);
			tsat_s4 <= (dnorm >= ONE_FX);
			rgb_s4  <= rgb_t'(side2[23:0]);
		end
	end

	// t = (d - radius) * 2^16 / (1 - radius)
	logic            vld_q2;
	logic [FRAC-1:0] quo2;
	logic [25:0]     side3;
	rvp_div_pipe #(.RW(FX_W), .QW(FRAC), .SW(26)) u_fall_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s4),
		.rem0     (dif_s4),
		.dvs      (ONE_FX - radius_q),
		.feed     ({FRAC{1'b0}}),
		.side_in  ({tsat_s4, act_s4, rgb_s4}),
		.out_valid(vld_q2),
		.quot     (quo2),
		.side_out (side3)
	);

	logic [FX_W-1:0] tval;
	assign tval = side3[25] ? ONE_FX : {1'b0, quo2};

	// stages 5..7: t squared, factor, channel scaling
	logic              vld_s5, vld_s6, act_s5;
	logic [FX_W-1:0]   t2_s5, f_s6;
	rgb_t              rgb_s5, rgb_s6, rgb_s7;
	logic [2*FX_W-1:0] tt_c, st_c;
	logic [24:0]       pr_c, pg_c, pb_c;

	assign tt_c = (2*FX_W)'(tval) * (2*FX_W)'(tval);
	assign st_c = (2*FX_W)'(str_eff) * (2*FX_W)'(t2_s5);
	assign pr_c = 25'(rgb_s6.red)   * 25'(f_s6);
	assign pg_c = 25'(rgb_s6.green) * 25'(f_s6);
	assign pb_c = 25'(rgb_s6.blue)  * 25'(f_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_q2;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s5  <= tt_c[FRAC+FX_W-1:FRAC];
			act_s5 <= side3[24];
			rgb_s5 <= rgb_t'(side3[23:0]);
			f_s6   <= act_s5 ? (ONE_FX - st_c[FRAC+FX_W-1:FRAC]) : ONE_FX;
			rgb_s6 <= rgb_s5;
			rgb_s7.red   <= (pr_c[24:16] > 9'd255) ? 8'hFF : pr_c[23:16];
			rgb_s7.green <= (pg_c[24:16] > 9'd255) ? 8'hFF : pg_c[23:16];
			rgb_s7.blue  <= (pb_c[24:16] > 9'd255) ? 8'hFF : pb_c[23:16];
		end
	end

	assign m_tvalid = vld_s7;
	assign m_tdata  = rgb_s7;
endmodule
`default_nettype wire

### rtl/rvp_checker.sv
// Port-level checks for radial_vignette_pixel_top, bound to it below.
// Depends on radial_vignette_pixel_top_macros.svh.
`default_nettype none
`include "radial_vignette_pixel_top_macros.svh"
module rvp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);
	// a held result keeps its value
	`RVP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

	// intake stalls exactly when a result waits
	`RVP_ASSERT_ALWAYS(a_ready_follows, s_tready == (!m_tvalid || m_tready), "s_tready out of step with output")

	// nothing leaves while in reset
	`RVP_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_tvalid, "output valid during reset")
endmodule

bind radial_vignette_pixel_top rvp_checker u_rvp_checker (.*);
`default_nettype wire

### test/radial_vignette_pixel_top_tb.sv
// Self-checking bench for radial_vignette_pixel_top: random and directed pixels
// against a bit-exact vignette predictor, under several handshake idle patterns.
// Depends on rvp_pkg and the block's RTL.
`default_nettype none
module radial_vignette_pixel_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rvp_pkg::*;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_rgb_t;

	// Scoreboard: vignette predictor plus a queue of expected pixels
	class vignette_board;
		logic [12:0] width, height;
		logic [16:0] radius, strength;
		pixel_rgb_t  pending[$];
		int          errors;
		int          checked;

		function new();
			width = 640;
			height = 480;
			radius = 32768;
			strength = 32768;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [16:0] value);
			case (idx)
				CFG_WIDTH: begin
					width = value[12:0];
				end
				CFG_HEIGHT: begin
					height = value[12:0];
				end
				CFG_RADIUS: begin
					radius = value;
				end
				default: begin
					strength = value;
				end
			endcase
		endfunction

		static function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function logic [7:0] scale(logic [7:0] c, longint unsigned f);
			longint unsigned v;
			v = (c * f) >> 16;
			return (v > 255) ? 8'd255 : v[7:0];
		endfunction

		// Note an accepted pixel and queue its darkened value
		function void note_pixel(logic [47:0] data);
			longint unsigned w, h, den, f, st, num, ratio, d, t, t2, adx, ady;
			longint signed dx, dy;
			pixel_rgb_t exp_px;
			w = (width > 4096) ? 4096 : width;
			h = (height > 4096) ? 4096 : height;
			st = (strength > 65536) ? 65536 : strength;
			den = w * w + h * h;
			f = 65536;
			if (den != 0 && radius < 65536) begin
				dx = 2 * longint'(data[11:0]) - longint'(w);
				dy = 2 * longint'(data[23:12]) - longint'(h);
				adx = (dx < 0) ? -dx : dx;
				ady = (dy < 0) ? -dy : dy;
				num = adx * adx + ady * ady;
				ratio = (num << 16) / den;
				if (ratio > 4 * 65536 - 1)
					ratio = 4 * 65536 - 1;
				d = int_sqrt(ratio << 16);
				if (d > radius) begin
					t = ((d - radius) << 16) / (65536 - radius);
					if (t > 65536)
						t = 65536;
					t2 = (t * t) >> 16;
					f = 65536 - ((st * t2) >> 16);
				end
			end
			exp_px.red = scale(data[31:24], f);
			exp_px.green = scale(data[39:32], f);
			exp_px.blue = scale(data[47:40], f);
			pending.push_back(exp_px);
		endfunction

		// Compare one output transfer with the oldest expectation
		function void check_pixel(logic [23:0] data);
			pixel_rgb_t e;
			if (pending.size() == 0) begin
				$error("unexpected output transfer %h", data);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (data[7:0] !== e.red) begin
				$error("red_out expected %0d got %0d", e.red, data[7:0]);
				errors++;
			end
			if (data[15:8] !== e.green) begin
				$error("green_out expected %0d got %0d", e.green, data[15:8]);
				errors++;
			end
			if (data[23:16] !== e.blue) begin
				$error("blue_out expected %0d got %0d", e.blue, data[23:16]);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n = 1;
	logic              s_tvalid = 0;
	logic              s_tready;
	logic [47:0]       s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 0;
	logic [23:0]       m_tdata;
	logic              cfg_we = 0;
	logic [1:0]        cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;

	vignette_board board = new();
	int  src_idle_pct = 0;
	int  sink_stall_pct = 0;
	bit  hold_off = 0;
	longint cycles = 0;

	radial_vignette_pixel_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("radial_vignette_pixel_top_tb: FAIL");
			$finish;
		end
	end

	// Output sampling
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_pixel(m_tdata);
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic write_reg(cfg_idx_t idx, logic [16:0] value);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
		board.set_reg(idx, value);
	endtask

	// Present one pixel, holding it until the transfer happens
	task automatic send_pixel(logic [11:0] col, logic [11:0] row,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {b, g, r, row, col};
		do
			@(posedge clk);
		while (!s_tready);
		board.note_pixel({b, g, r, row, col});
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic random_pixels(int n);
		logic [11:0] c, r;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 7) begin
				c = 12'($urandom_range(board.width));
				r = 12'($urandom_range(board.height));
			end else begin
				c = 12'($urandom);
				r = 12'($urandom);
			end
			send_pixel(c, r, 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		arst_n <= 0;
		repeat (7) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: corners, center, outside, channel extremes at reset config
		send_pixel(0, 0, 255, 255, 255);
		send_pixel(320, 240, 255, 128, 0);
		send_pixel(639, 479, 255, 255, 255);
		send_pixel(4095, 4095, 255, 1, 254);
		send_pixel(4095, 0, 0, 0, 0);
		send_pixel(0, 4095, 170, 85, 255);
		send_pixel(100, 400, 255, 255, 255);
		drain();
		// Radius at 1.0 and above: no darkening
		write_reg(CFG_RADIUS, 17'd65536);
		send_pixel(0, 0, 255, 255, 255);
		drain();
		write_reg(CFG_RADIUS, 17'd0);
		write_reg(CFG_STRENGTH, 17'h1FFFF);
		send_pixel(0, 0, 255, 255, 255);
		send_pixel(1, 1, 200, 100, 50);
		drain();
		// Width above limit and height at limit, then zero width and height
		write_reg(CFG_WIDTH, 13'h1FFF);
		write_reg(CFG_HEIGHT, 13'd4096);
		send_pixel(4095, 4095, 255, 255, 255);
		send_pixel(2048, 2048, 255, 255, 255);
		drain();
		write_reg(CFG_WIDTH, 13'd0);
		write_reg(CFG_HEIGHT, 13'd0);
		send_pixel(4095, 4095, 255, 255, 255);
		drain();

		// Random phases across settings and idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_WIDTH, 17'((ph % 3 == 0) ? 1 : $urandom_range(4096, 1)));
			write_reg(CFG_HEIGHT, 17'((ph == 5) ? 4096 : $urandom_range(4096, 1)));
			write_reg(CFG_RADIUS, 17'((ph == 1) ? 0 : $urandom_range(65536)));
			write_reg(CFG_STRENGTH, 17'((ph == 2) ? 65536 : $urandom_range(65536)));
			case (ph % 4)
				0: begin src_idle_pct = 0; sink_stall_pct = 0; end
				1: begin src_idle_pct = 66; sink_stall_pct = 0; end
				2: begin src_idle_pct = 0; sink_stall_pct = 66; end
				default: begin src_idle_pct = 22; sink_stall_pct = 22; end
			endcase
			if (ph == 4) begin
				// Long receiver hold-off while pixels keep coming
				fork
					begin
						hold_off = 1;
						repeat (200) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			random_pixels(150);
			drain();
		end
		src_idle_pct = 0;
		sink_stall_pct = 0;
		drain();

		$display("Checked %0d pixels over directed cases and 8 random config phases.",
			board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("radial_vignette_pixel_top_tb: PASS");
		else
			$display("radial_vignette_pixel_top_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/rvp_pkg.sv
rtl/rvp_div_pipe.sv
rtl/rvp_sqrt_pipe.sv
rtl/radial_vignette_pixel_top.sv
rtl/rvp_checker.sv
test/radial_vignette_pixel_top_tb.sv
